FILE: hw/rtl/xfb_pkg.sv
// Shared types and constants of the scrolling XOR framebuffer.
// No dependencies; xfb_in_if, xfb_index_div and the core use this package.
`default_nettype none

package xfb_pkg;

  // Default geometry of the display
  localparam int BASE_WIDTH_DEF       = 64;
  localparam int BASE_HEIGHT_DEF      = 32;
  localparam int MAX_SCALE_DEF        = 2;
  localparam int SIDE_SCROLL_STEP_DEF = 4;

  // Fixed field widths of the channels
  localparam int KIND_W   = 3;
  localparam int COORD_W  = 8;
  localparam int SCROLL_W = 4;
  localparam int SCALE_W  = 2;

  // Index unit: remainder holds x (< 256) or y plus a carry of x / width
  localparam int REM_W   = COORD_W + 1;
  localparam int CARRY_W = COORD_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_FLIP   = 3'd0,
    KIND_DOWN   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_LEFT   = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_SCALE  = 3'd5,
    KIND_READ   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_PIX_RD,
    ST_PIX_WB,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } xfb_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_COL,
    DIV_ROW
  } div_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/xfb_in_if.sv
// Command channel of the framebuffer: valid/ready plus one operation.
// Depends on xfb_pkg for the field widths.
`default_nettype none

interface xfb_in_if;
  logic                         valid;
  logic                         ready;
  logic [xfb_pkg::KIND_W-1:0]   kind;
  logic [xfb_pkg::COORD_W-1:0]  x_coord;
  logic [xfb_pkg::COORD_W-1:0]  y_coord;
  logic [xfb_pkg::SCROLL_W-1:0] scroll_rows;
  logic [xfb_pkg::SCALE_W-1:0]  scale;

  modport source (output valid, kind, x_coord, y_coord, scroll_rows, scale, input ready);
  modport sink   (input valid, kind, x_coord, y_coord, scroll_rows, scale, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/xfb_out_if.sv
// Result channel of the framebuffer: valid/ready plus the old pixel value.
// No dependencies.
`default_nettype none

interface xfb_out_if;
  logic valid;
  logic ready;
  logic pixel_was;

  modport source (output valid, pixel_was, input ready);
  modport sink   (input valid, pixel_was, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/xfb_row_mem.sv
// Pixel store: one row of the largest picture per entry, one write and
// one registered read per cycle. Depends on nothing but its parameters.
`default_nettype none

module xfb_row_mem #(
  parameter int ROWS     = 64,
  parameter int ROW_BITS = 128
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [$clog2(ROWS)-1:0] waddr,
  input  wire logic [ROW_BITS-1:0]     wdata,
  input  wire logic [$clog2(ROWS)-1:0] raddr,
  output logic      [ROW_BITS-1:0]     rdata
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/xfb_index_div.sv
// Iterative pixel addressing: column = x mod width, row = (y + x / width)
// mod height, worked out by one shared subtractor. Depends on xfb_pkg.
`default_nettype none

module xfb_index_div #(
  parameter int BASE_WIDTH  = 64,
  parameter int BASE_HEIGHT = 32,
  parameter int MAX_SCALE   = 2
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          start,
  input  wire logic [xfb_pkg::COORD_W-1:0]                   x_coord,
  input  wire logic [xfb_pkg::COORD_W-1:0]                   y_coord,
  input  wire logic                                          scale_hi,
  output logic                                               done,
  output logic [$clog2(BASE_WIDTH*MAX_SCALE)-1:0]            col,
  output logic [$clog2(BASE_HEIGHT*MAX_SCALE)-1:0]           row
);

  import xfb_pkg::*;

  localparam int COL_W  = $clog2(BASE_WIDTH*MAX_SCALE);
  localparam int ROW_AW = $clog2(BASE_HEIGHT*MAX_SCALE);

  localparam logic [REM_W-1:0] W_LO = REM_W'(BASE_WIDTH);
  localparam logic [REM_W-1:0] W_HI = REM_W'(BASE_WIDTH*2);
  localparam logic [REM_W-1:0] H_LO = REM_W'(BASE_HEIGHT);
  localparam logic [REM_W-1:0] H_HI = REM_W'(BASE_HEIGHT*2);

  div_state_t          state_r, state_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [CARRY_W-1:0]  carry_r, carry_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_AW-1:0]   row_r, row_nxt;
  logic                done_r, done_nxt;

  logic [REM_W-1:0]    divisor;
  logic [REM_W:0]      diff;
  logic                fits;

  // Shared subtractor: width while resolving the column, height for the row
  always_comb begin
    if (state_r == DIV_COL) begin
      divisor = scale_hi ? W_HI : W_LO;
    end else begin
      divisor = scale_hi ? H_HI : H_LO;
    end
    diff = {1'b0, rem_r} - {1'b0, divisor};
    fits = !diff[REM_W];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          state_nxt = DIV_COL;
        end
      end
      DIV_COL: begin
        if (!fits) begin
          state_nxt = DIV_ROW;
        end
      end
      DIV_ROW: begin
        if (!fits) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt   = rem_r;
    carry_nxt = carry_r;
    y_nxt     = y_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          rem_nxt   = REM_W'(x_coord);
          carry_nxt = '0;
          y_nxt     = y_coord;
        end
      end
      DIV_COL: begin
        if (fits) begin
          rem_nxt   = diff[REM_W-1:0];
          carry_nxt = carry_r + CARRY_W'(1);
        end else begin
          col_nxt = rem_r[COL_W-1:0];
          rem_nxt = REM_W'(y_r) + REM_W'(carry_r);
        end
      end
      DIV_ROW: begin
        if (fits) begin
          rem_nxt = diff[REM_W-1:0];
        end else begin
          row_nxt  = rem_r[ROW_AW-1:0];
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    rem_r   <= rem_nxt;
    carry_r <= carry_nxt;
    y_r     <= y_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
  end

  assign done = done_r;
  assign col  = col_r;
  assign row  = row_r;

endmodule

`default_nettype wire

FILE: hw/rtl/xor_framebuffer_with_scroll_core.sv
// One-bit framebuffer with XOR flip, scrolls, clear and scale change.
// Depends on xfb_pkg, xfb_in_if, xfb_out_if, xfb_row_mem, xfb_index_div.
//
// in_ch carries one operation per transfer; out_ch returns exactly one
// result per operation, in order: the old pixel for flip and read, else 0.
// The block handles one operation at a time; in_ch.ready is high only when
// it is idle. A finished result sits in an output register, so the next
// operation is taken while that result waits for out_ch.ready.
// Flip and read: the pixel address is resolved by one shared subtractor,
// one subtract per cycle; then the row is read, the pixel is written back
// (flip only) and the result is posted.
// Scrolls sweep the active rows, clear and scale change sweep all stored
// rows, one row per cycle through the single row memory (one read, one
// write port).
// After reset the block runs a clearing pass over all BASE_HEIGHT *
// MAX_SCALE rows before it raises in_ch.ready.
// A stalled receiver holds the result; at most one more operation is then
// worked off before the block waits for out_ch.ready.
`default_nettype none

module xor_framebuffer_with_scroll_core #(
  parameter int BASE_WIDTH       = xfb_pkg::BASE_WIDTH_DEF,
  parameter int BASE_HEIGHT      = xfb_pkg::BASE_HEIGHT_DEF,
  parameter int MAX_SCALE        = xfb_pkg::MAX_SCALE_DEF,
  parameter int SIDE_SCROLL_STEP = xfb_pkg::SIDE_SCROLL_STEP_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  xfb_in_if.sink    in_ch,
  xfb_out_if.source out_ch
);

  import xfb_pkg::*;

  localparam int ROWS     = BASE_HEIGHT * MAX_SCALE;
  localparam int ROW_BITS = BASE_WIDTH * MAX_SCALE;
  localparam int ROW_AW   = $clog2(ROWS);
  localparam int COL_W    = $clog2(ROW_BITS);
  localparam int SUB_W    = (ROW_AW > SCROLL_W) ? ROW_AW + 1 : SCROLL_W + 1;

  localparam logic [ROW_BITS-1:0] MASK_HI = {ROW_BITS{1'b1}};
  localparam logic [ROW_BITS-1:0] MASK_LO = MASK_HI >> (ROW_BITS - BASE_WIDTH);
  localparam logic [ROW_AW-1:0]   LAST_HI = ROW_AW'(ROWS - 1);
  localparam logic [ROW_AW-1:0]   LAST_LO = ROW_AW'(BASE_HEIGHT - 1);

  xfb_state_t           state_r, state_nxt;
  kind_t                op_r, op_nxt;
  logic                 hi_r, hi_nxt;
  logic                 resp_r, resp_nxt;
  logic [ROW_AW-1:0]    cnt_r, cnt_nxt;
  logic [SCROLL_W-1:0]  shift_n_r, shift_n_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [ROW_AW-1:0]    pend_row_r, pend_row_nxt;
  logic                 pend_zero_r, pend_zero_nxt;
  logic                 pix_r, pix_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_pix_r, out_pix_nxt;

  kind_t                in_kind;
  logic                 in_fire;
  logic                 out_free;

  logic                 mem_we;
  logic [ROW_AW-1:0]    mem_waddr;
  logic [ROW_BITS-1:0]  mem_wdata;
  logic [ROW_AW-1:0]    mem_raddr;
  logic [ROW_BITS-1:0]  mem_rdata;

  logic                 idx_start;
  logic                 idx_done;
  logic [COL_W-1:0]     idx_col;
  logic [ROW_AW-1:0]    idx_row;

  logic [ROW_BITS-1:0]  row_mask;
  logic [ROW_BITS-1:0]  sweep_data;
  logic [SUB_W-1:0]     src_diff;
  logic                 src_ok;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_kind  = kind_t'(in_ch.kind);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign row_mask = hi_r ? MASK_HI : MASK_LO;

  // Scroll down: row r takes row r - n, rows above n become blank
  assign src_diff = SUB_W'(cnt_r) - SUB_W'(shift_n_r);
  assign src_ok   = !src_diff[SUB_W-1];

  xfb_index_div #(
    .BASE_WIDTH  (BASE_WIDTH),
    .BASE_HEIGHT (BASE_HEIGHT),
    .MAX_SCALE   (MAX_SCALE)
  ) u_index (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (idx_start),
    .x_coord  (in_ch.x_coord),
    .y_coord  (in_ch.y_coord),
    .scale_hi (hi_r),
    .done     (idx_done),
    .col      (idx_col),
    .row      (idx_row)
  );

  xfb_row_mem #(
    .ROWS     (ROWS),
    .ROW_BITS (ROW_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            KIND_FLIP, KIND_READ:                  state_nxt = ST_INDEX;
            KIND_DOWN, KIND_RIGHT, KIND_LEFT,
            KIND_CLEAR, KIND_SCALE:                state_nxt = ST_SWEEP;
            default:                               state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          state_nxt = ST_PIX_RD;
        end
      end
      ST_PIX_RD: state_nxt = ST_PIX_WB;
      ST_PIX_WB: state_nxt = ST_FINISH;
      ST_SWEEP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = resp_r ? ST_FINISH : ST_IDLE;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Write data of a swept row, from the row read in the cycle before
  always_comb begin
    if (pend_zero_r) begin
      sweep_data = '0;
    end else begin
      unique case (op_r)
        KIND_RIGHT: sweep_data = (mem_rdata << SIDE_SCROLL_STEP) & row_mask;
        KIND_LEFT:  sweep_data = (mem_rdata >> SIDE_SCROLL_STEP) & row_mask;
        default:    sweep_data = mem_rdata;
      endcase
    end
  end

  always_comb begin
    op_nxt        = op_r;
    hi_nxt        = hi_r;
    resp_nxt      = resp_r;
    cnt_nxt       = cnt_r;
    shift_n_nxt   = shift_n_r;
    pend_vld_nxt  = pend_vld_r;
    pend_row_nxt  = pend_row_r;
    pend_zero_nxt = pend_zero_r;
    pix_nxt       = pix_r;
    out_pix_nxt   = out_pix_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    idx_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = pend_row_r;
    mem_wdata     = sweep_data;
    mem_raddr     = idx_row;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_kind;
          resp_nxt    = 1'b1;
          pix_nxt     = 1'b0;
          shift_n_nxt = in_ch.scroll_rows;
          idx_start   = (in_kind == KIND_FLIP) || (in_kind == KIND_READ);
          if ((in_kind == KIND_CLEAR) || (in_kind == KIND_SCALE)) begin
            cnt_nxt = LAST_HI;
          end else begin
            cnt_nxt = hi_r ? LAST_HI : LAST_LO;
          end
          if (in_kind == KIND_SCALE) begin
            hi_nxt = (MAX_SCALE > 1) && (in_ch.scale > SCALE_W'(1));
          end
        end
      end
      ST_PIX_WB: begin
        pix_nxt = mem_rdata[idx_col];
        if (op_r == KIND_FLIP) begin
          mem_we    = 1'b1;
          mem_waddr = idx_row;
          mem_wdata = mem_rdata ^ (ROW_BITS'(1) << idx_col);
        end
      end
      ST_SWEEP: begin
        pend_vld_nxt = 1'b1;
        pend_row_nxt = cnt_r;
        if (op_r == KIND_DOWN) begin
          mem_raddr     = src_diff[ROW_AW-1:0];
          pend_zero_nxt = !src_ok;
        end else begin
          mem_raddr     = cnt_r;
          pend_zero_nxt = (op_r == KIND_CLEAR) || (op_r == KIND_SCALE);
        end
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - ROW_AW'(1);
        end
      end
      ST_DRAIN: begin
        pend_vld_nxt = 1'b0;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_pix_nxt = pix_r;
        end
      end
      default: ;
    endcase

    // Write back the row read in the previous sweep cycle
    if (pend_vld_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      op_r       <= KIND_CLEAR;
      hi_r       <= 1'b0;
      resp_r     <= 1'b0;
      cnt_r      <= LAST_HI;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      op_r       <= op_nxt;
      hi_r       <= hi_nxt;
      resp_r     <= resp_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    shift_n_r   <= shift_n_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_zero_r <= pend_zero_nxt;
    pix_r       <= pix_nxt;
    out_pix_r   <= out_pix_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.pixel_was = out_pix_r;

endmodule

`default_nettype wire
